[rtl/abe_pkg.sv]
// abe_pkg: shared types, command codes and default sizes of the allocation bitmap engine
// no dependencies; imported by abe_word_op and the top level of the engine

package abe_pkg;

	// field widths of the request and response transactions
	localparam int CMD_W   = 3;
	localparam int INDEX_W = 10;
	localparam int SPAN_W  = 11;
	localparam int COUNT_W = 11;

	// default map geometry
	localparam int MAP_BITS_DEF  = 1024;
	localparam int WORD_BITS_DEF = 32;

	// widest word the per-word unit has to handle
	localparam int WORD_BITS_MAX = 64;
	localparam int WCNT_W        = $clog2(WORD_BITS_MAX) + 1;
	localparam int WPOS_W        = $clog2(WORD_BITS_MAX);

	// request commands
	localparam logic [CMD_W-1:0] CMD_WRITE_BIT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_RANGE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ_BIT    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_COUNT       = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND        = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [INDEX_W-1:0] bit_index;
		logic [INDEX_W-1:0] range_last;
		logic               bit_value_in;
		logic [SPAN_W-1:0]  span_bits;
	} req_t;

	typedef struct packed {
		logic               read_bit;
		logic [COUNT_W-1:0] bit_count;
		logic               found;
		logic [INDEX_W-1:0] found_index;
	} rsp_t;

	// per-word summary handed from the word unit to the sequencer
	typedef struct packed {
		logic [WCNT_W-1:0] cnt;
		logic              hit;
		logic [WPOS_W-1:0] pos;
		logic              bit_set;
	} word_res_t;

endpackage

[rtl/abe_ram.sv]
// abe_ram: generic single-clock ram, one write port and one read port, registered read data
// no dependencies

module abe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/abe_word_op.sv]
// abe_word_op: per-word logic of the engine: range mask, updated word, match count,
// lowest match and raw bit test; depends on abe_pkg

module abe_word_op #(
	parameter int WORD_BITS = abe_pkg::WORD_BITS_DEF,
	parameter int BASE_W    = 11
) (
	input  logic [WORD_BITS-1:0] rdata,
	input  logic [BASE_W-1:0]    base,
	input  logic [BASE_W-1:0]    lo,
	input  logic [BASE_W-1:0]    hi,
	input  logic                 value,
	output logic [WORD_BITS-1:0] wdata,
	output abe_pkg::word_res_t   res
);
	import abe_pkg::*;

	localparam int OFF_W = $clog2(WORD_BITS);

	logic [BASE_W-1:0]    lo_diff;
	logic [BASE_W-1:0]    hi_diff;
	logic [OFF_W-1:0]     lo_off;
	logic [OFF_W-1:0]     hi_off;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] match;
	logic [WCNT_W-1:0]    cnt;
	logic [WPOS_W-1:0]    pos;

	// offsets of the first and last covered bit inside this word
	always_comb begin
		lo_diff = lo - base;
		hi_diff = hi - base;
		lo_off  = (lo > base) ? lo_diff[OFF_W-1:0] : '0;
		hi_off  = (hi_diff < BASE_W'(WORD_BITS)) ? hi_diff[OFF_W-1:0]
		                                         : OFF_W'(WORD_BITS - 1);
	end

	// covered bits of the word
	always_comb begin
		for (int p = 0; p < WORD_BITS; p++) begin
			mask[p] = (OFF_W'(p) >= lo_off) && (OFF_W'(p) <= hi_off);
		end
	end

	// updated word and matching bits
	assign wdata = value ? (rdata | mask) : (rdata & ~mask);
	assign match = (value ? rdata : ~rdata) & mask;

	// population count of the matches
	always_comb begin
		cnt = '0;
		for (int p = 0; p < WORD_BITS; p++) begin
			cnt = cnt + WCNT_W'(match[p]);
		end
	end

	// lowest matching position
	always_comb begin
		pos = '0;
		for (int p = WORD_BITS - 1; p >= 0; p--) begin
			if (match[p]) begin
				pos = WPOS_W'(p);
			end
		end
	end

	assign res.cnt     = cnt;
	assign res.hit     = |match;
	assign res.pos     = pos;
	assign res.bit_set = |(rdata & mask);

endmodule

[rtl/allocation_bitmap_engine.sv]
// allocation_bitmap_engine: top level; request sequencer, bitmap ram and response register
// depends on abe_pkg, abe_ram and abe_word_op
//
// channel  | signals                    | direction | content
// ---------+----------------------------+-----------+-----------------------------------
// req      | req_valid, req_stall, req  | into      | command, index, range, value, span
// rsp      | rsp_valid, rsp_stall, rsp  | out of    | read bit, count, found, found index
//
// one request at a time; a taken request passes the states div, base, walk and done,
// its map words streamed through the ram read port one per cycle during the walk; done
// waits until the response register is free, and the next request is taken once the
// sequencer is back in idle; empty ranges and unknown commands go from idle straight to done
// after reset a clearing pass writes zero to every map word, with req_stall high; a finished
// response waits in its register under rsp_stall while the next request is already taken

module allocation_bitmap_engine #(
	parameter int MAP_BITS  = abe_pkg::MAP_BITS_DEF,
	parameter int WORD_BITS = abe_pkg::WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  abe_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output abe_pkg::rsp_t rsp
);
	import abe_pkg::*;

	localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BASE_W    = $clog2(MAP_BITS) + 1;
	localparam int EXT_W     = (BASE_W > SPAN_W) ? BASE_W : SPAN_W;
	localparam int WOFF_W    = $clog2(WORD_BITS);
	// word index by reciprocal multiplication, exact for every index below 2**BASE_W
	localparam int DIV_SH    = BASE_W + WOFF_W + 1;
	localparam int RECIP_W   = DIV_SH - WOFF_W + 2;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << DIV_SH) / WORD_BITS + 1);
	localparam int PROD_W    = BASE_W + RECIP_W;

	// sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_BASE  = 3'd3;
	localparam logic [2:0] ST_WALK  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]           state_q;
	logic [CMD_W-1:0]     cmd_q;
	logic                 val_q;
	logic [BASE_W-1:0]    lo_q;
	logic [BASE_W-1:0]    hi_q;
	logic [ADDR_W-1:0]    lo_w_q;
	logic [BASE_W-1:0]    base_q;
	logic [ADDR_W-1:0]    addr_q;
	logic                 stop_q;
	logic                 v_s1;
	logic                 last_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic [BASE_W-1:0]    base_s1;
	logic [COUNT_W-1:0]   cnt_q;
	logic                 fnd_q;
	logic [BASE_W-1:0]    fidx_q;
	logic                 rbit_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 accept;
	logic [EXT_W-1:0]     idx_x;
	logic [EXT_W-1:0]     last_x;
	logic [EXT_W-1:0]     span_x;
	logic [EXT_W-1:0]     map_x;
	logic [EXT_W-1:0]     lo_n;
	logic [EXT_W-1:0]     hi_n;
	logic                 empty_n;
	logic [PROD_W-1:0]    div_prod;
	logic [BASE_W-1:0]    lo_w_ext;
	logic [BASE_W-1:0]    hi_rem;
	logic                 last_issue;
	logic                 rd_en;
	logic                 is_write;
	logic                 we;
	logic [ADDR_W-1:0]    waddr;
	logic [WORD_BITS-1:0] wdata;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] new_word;
	word_res_t            wres;
	logic                 rsp_free;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// bit interval a request covers, and whether it covers nothing
	always_comb begin
		idx_x   = EXT_W'(req.bit_index);
		last_x  = EXT_W'(req.range_last);
		span_x  = EXT_W'(req.span_bits);
		map_x   = EXT_W'(MAP_BITS);
		lo_n    = idx_x;
		hi_n    = idx_x;
		empty_n = 1'b1;
		unique case (req.cmd)
			CMD_WRITE_BIT, CMD_READ_BIT: begin
				empty_n = (idx_x >= map_x);
			end
			CMD_WRITE_RANGE: begin
				hi_n    = (last_x >= map_x) ? map_x - EXT_W'(1) : last_x;
				empty_n = (hi_n < idx_x);
			end
			CMD_COUNT, CMD_FIND: begin
				lo_n    = '0;
				hi_n    = ((span_x > map_x) ? map_x : span_x) - EXT_W'(1);
				empty_n = (span_x == '0);
			end
			default: begin
				empty_n = 1'b1;
			end
		endcase
	end

	// word address of the first covered bit, and distance to the last one
	assign div_prod   = PROD_W'(lo_q) * PROD_W'(RECIP);
	assign lo_w_ext   = BASE_W'(lo_w_q);
	assign hi_rem     = hi_q - base_q;
	assign last_issue = (hi_rem < BASE_W'(WORD_BITS));

	assign rd_en    = (state_q == ST_WALK) && !stop_q;
	assign is_write = (cmd_q == CMD_WRITE_BIT) || (cmd_q == CMD_WRITE_RANGE);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			stop_q      <= 1'b0;
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			// response valid: set when a result is loaded, cleared when taken
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == ADDR_W'(MAP_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= empty_n ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					state_q <= ST_BASE;
				end
				ST_BASE: begin
					addr_q  <= lo_w_q;
					stop_q  <= 1'b0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (rd_en) begin
						addr_q <= addr_q + 1'b1;
						stop_q <= last_issue;
					end
					if (v_s1 && last_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request registers, walk position and accumulators
	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		base_s1 <= base_q;
		last_s1 <= last_issue;
		if (accept) begin
			cmd_q  <= req.cmd;
			val_q  <= req.bit_value_in;
			lo_q   <= BASE_W'(lo_n);
			hi_q   <= BASE_W'(hi_n);
			cnt_q  <= '0;
			fnd_q  <= 1'b0;
			fidx_q <= '0;
			rbit_q <= 1'b0;
		end
		if (state_q == ST_DIV) begin
			lo_w_q <= div_prod[DIV_SH +: ADDR_W];
		end
		if (state_q == ST_BASE) begin
			base_q <= lo_w_ext * BASE_W'(WORD_BITS);
		end else if (rd_en) begin
			base_q <= base_q + BASE_W'(WORD_BITS);
		end
		if (v_s1) begin
			cnt_q  <= cnt_q + COUNT_W'(wres.cnt);
			rbit_q <= rbit_q | wres.bit_set;
			if (wres.hit && !fnd_q) begin
				fnd_q  <= 1'b1;
				fidx_q <= base_s1 + BASE_W'(wres.pos);
			end
		end
	end

	// response register, each field only for its own command
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free) begin
			rsp_q.read_bit    <= (cmd_q == CMD_READ_BIT) && rbit_q;
			rsp_q.bit_count   <= (cmd_q == CMD_COUNT) ? cnt_q : '0;
			rsp_q.found       <= (cmd_q == CMD_FIND) && fnd_q;
			rsp_q.found_index <= ((cmd_q == CMD_FIND) && fnd_q) ? INDEX_W'(fidx_q) : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ram write port: clearing pass or write-back of the word in stage one
	assign we    = (state_q == ST_CLEAR) || (v_s1 && is_write);
	assign waddr = (state_q == ST_CLEAR) ? addr_q : addr_s1;
	assign wdata = (state_q == ST_CLEAR) ? '0 : new_word;

	abe_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(addr_q),
		.rdata(rdata)
	);

	abe_word_op #(
		.WORD_BITS(WORD_BITS),
		.BASE_W   (BASE_W)
	) u_word (
		.rdata(rdata),
		.base (base_s1),
		.lo   (lo_q),
		.hi   (hi_q),
		.value(val_q),
		.wdata(new_word),
		.res  (wres)
	);

`ifndef SYNTHESIS
	// a word comes back from the ram only while walking
	a_s1_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> state_q == ST_WALK)
		else $error("word in stage one outside of a walk");

	// the map is written only by the clearing pass or a write command
	a_write_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_CLEAR || cmd_q == CMD_WRITE_BIT || cmd_q == CMD_WRITE_RANGE))
		else $error("map written by a non-write command");

	// reads stay inside the map
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> addr_q <= ADDR_W'(MAP_WORDS - 1))
		else $error("read beyond the last map word");

	// no response before the clearing pass is over
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !rsp_valid)
		else $error("response during the clearing pass");

	// a found index lies inside the searched interval
	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && fnd_q) |-> fidx_q <= hi_q)
		else $error("found index beyond the search span");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for allocation_bitmap_engine; a scoreboard keeps a mirror of the
// allocation map and predicts every response; depends on abe_pkg and the engine rtl

module tb;
	import abe_pkg::*;

	localparam int MAP_BITS     = MAP_BITS_DEF;
	localparam int SPAN_MAX     = (1 << SPAN_W) - 1;
	localparam int N_RANDOM     = 430;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 40;

	// command codes the engine does not know
	localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_FIND + 1'b1;
	localparam logic [CMD_W-1:0] CMD_LAST_CODE    = {CMD_W{1'b1}};

	// mirror of the allocation map and queue of responses still owed
	class bitmap_scoreboard;
		bit [MAP_BITS-1:0] alloc_map;
		rsp_t              expected_rsp[$];
		int                errors;

		// apply one accepted request to the mirror and queue its response
		function void take_request(req_t r);
			rsp_t e;
			int   last_bit;
			int   span;
			e = '0;
			span = (r.span_bits > MAP_BITS) ? MAP_BITS : int'(r.span_bits);
			case (r.cmd)
			CMD_WRITE_BIT: begin
				if (r.bit_index < MAP_BITS)
					alloc_map[r.bit_index] = r.bit_value_in;
			end
			CMD_WRITE_RANGE: begin
				last_bit = (r.range_last >= MAP_BITS) ? MAP_BITS - 1 : int'(r.range_last);
				for (int i = int'(r.bit_index); i <= last_bit; i++)
					alloc_map[i] = r.bit_value_in;
			end
			CMD_READ_BIT: begin
				if (r.bit_index < MAP_BITS)
					e.read_bit = alloc_map[r.bit_index];
			end
			CMD_COUNT: begin
				for (int i = 0; i < span; i++)
					if (alloc_map[i] == r.bit_value_in)
						e.bit_count = e.bit_count + 1'b1;
			end
			CMD_FIND: begin
				for (int i = 0; i < span; i++) begin
					if (alloc_map[i] == r.bit_value_in) begin
						e.found       = 1'b1;
						e.found_index = INDEX_W'(i);
						break;
					end
				end
			end
			default: ;
			endcase
			expected_rsp.push_back(e);
		endfunction

		// compare one accepted response with the oldest expectation
		function void check_response(rsp_t a);
			rsp_t e;
			if (expected_rsp.size() == 0) begin
				$error("response with nothing expected: %p", a);
				errors++;
				return;
			end
			e = expected_rsp.pop_front();
			if (a.read_bit !== e.read_bit) begin
				$error("read_bit: expected %0d, got %0d", e.read_bit, a.read_bit);
				errors++;
			end
			if (a.bit_count !== e.bit_count) begin
				$error("bit_count: expected %0d, got %0d", e.bit_count, a.bit_count);
				errors++;
			end
			if (a.found !== e.found) begin
				$error("found: expected %0d, got %0d", e.found, a.found);
				errors++;
			end
			if (a.found_index !== e.found_index) begin
				$error("found_index: expected %0d, got %0d", e.found_index, a.found_index);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	bitmap_scoreboard sb = new;
	int               idle_cycles = 0;
	int               tx_nogap_left;
	bit               hold_request;

	allocation_bitmap_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// transaction monitor on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
			if (req_valid && !req_stall)
				sb.take_request(req);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic req_t request(logic [CMD_W-1:0] cmd, int first, int last, bit val,
			int span);
		req_t r;
		r.cmd          = cmd;
		r.bit_index    = INDEX_W'(first);
		r.range_last   = INDEX_W'(last);
		r.bit_value_in = val;
		r.span_bits    = SPAN_W'(span);
		return r;
	endfunction

	// span for count and find: zero, whole map, past the map, short and general
	function automatic int random_span();
		int k;
		k = $urandom_range(0, 99);
		if (k < 8)
			return 0;
		else if (k < 16)
			return MAP_BITS;
		else if (k < 26)
			return $urandom_range(MAP_BITS + 1, SPAN_MAX);
		else if (k < 50)
			return $urandom_range(1, 64);
		return $urandom_range(1, MAP_BITS - 1);
	endfunction

	// mostly well-formed requests with random content, a few unknown commands
	function automatic req_t random_request();
		req_t r;
		int   sel;
		int   k;
		int   first;
		int   last;
		r = request(CMD_WRITE_BIT, $urandom_range(0, MAP_BITS - 1),
			$urandom_range(0, MAP_BITS - 1), bit'($urandom_range(0, 1)),
			$urandom_range(0, SPAN_MAX));
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			r.cmd = CMD_WRITE_BIT;
		end else if (sel < 45) begin
			r.cmd = CMD_WRITE_RANGE;
			first = int'(r.bit_index);
			k = $urandom_range(0, 99);
			if (k < 8 && first > 0) begin
				// reversed range
				last = $urandom_range(0, first - 1);
			end else if (k < 12) begin
				first = 0;
				last  = MAP_BITS - 1;
			end else if (k < 75) begin
				last = first + $urandom_range(0, 40);
			end else begin
				last = first + $urandom_range(0, MAP_BITS - 1);
			end
			if (last > MAP_BITS - 1)
				last = MAP_BITS - 1;
			r.bit_index  = INDEX_W'(first);
			r.range_last = INDEX_W'(last);
		end else if (sel < 63) begin
			r.cmd = CMD_READ_BIT;
		end else if (sel < 78) begin
			r.cmd       = CMD_COUNT;
			r.span_bits = SPAN_W'(random_span());
		end else if (sel < 95) begin
			r.cmd       = CMD_FIND;
			r.span_bits = SPAN_W'(random_span());
		end else begin
			r.cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
		end
		return r;
	endfunction

	// offer one request after a random gap and hold it until taken
	task automatic send_req(req_t r);
		int gap;
		if (tx_nogap_left > 0) begin
			gap = 0;
			tx_nogap_left--;
		end else begin
			if ($urandom_range(0, 19) == 0)
				tx_nogap_left = $urandom_range(10, 30);
			gap = $urandom_range(0, 6);
		end
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       = r;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// response side: random stall before each transaction, one long hold-off on request
	initial begin : rsp_side
		int wait_cycles;
		int nostall_left;
		rsp_stall    = 1'b0;
		nostall_left = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				wait_cycles  = HOLD_CYCLES;
			end else if (nostall_left > 0) begin
				wait_cycles = 0;
				nostall_left--;
			end else begin
				if ($urandom_range(0, 19) == 0)
					nostall_left = $urandom_range(10, 30);
				wait_cycles = $urandom_range(0, 6);
			end
			if (wait_cycles > 0) begin
				rsp_stall = 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			rsp_stall = 1'b0;
			do @(posedge clk); while (!rsp_valid);
			@(negedge clk);
		end
	end

	// reset, directed requests, random requests, drain and verdict
	initial begin : stimulus
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		tx_nogap_left = 0;
		hold_request  = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty map after reset
		send_req(request(CMD_READ_BIT, 0, 0, 1'b0, 0));
		send_req(request(CMD_COUNT, 0, 0, 1'b1, MAP_BITS));
		send_req(request(CMD_COUNT, 0, 0, 1'b0, SPAN_MAX));
		send_req(request(CMD_FIND, 0, 0, 1'b1, MAP_BITS));
		send_req(request(CMD_FIND, 0, 0, 1'b0, 0));
		// end bits of the map
		send_req(request(CMD_WRITE_BIT, 0, 0, 1'b1, 0));
		send_req(request(CMD_WRITE_BIT, MAP_BITS - 1, 0, 1'b1, 0));
		send_req(request(CMD_READ_BIT, MAP_BITS - 1, 0, 1'b0, 0));
		send_req(request(CMD_FIND, 0, 0, 1'b1, SPAN_MAX));
		// reversed range writes nothing
		send_req(request(CMD_WRITE_RANGE, 5, 3, 1'b1, 0));
		send_req(request(CMD_COUNT, 0, 0, 1'b1, 16));
		// ranges: long, single bit, whole map both ways
		send_req(request(CMD_WRITE_RANGE, 10, MAP_BITS - 1, 1'b1, 0));
		send_req(request(CMD_WRITE_RANGE, 700, 700, 1'b0, 0));
		send_req(request(CMD_FIND, 0, 0, 1'b0, MAP_BITS));
		send_req(request(CMD_WRITE_RANGE, 0, MAP_BITS - 1, 1'b0, 0));
		send_req(request(CMD_WRITE_RANGE, 0, MAP_BITS - 1, 1'b1, SPAN_MAX));
		// one hole in a full map
		send_req(request(CMD_WRITE_BIT, 517, 0, 1'b0, 0));
		send_req(request(CMD_FIND, 0, 0, 1'b0, MAP_BITS));
		send_req(request(CMD_COUNT, 0, 0, 1'b0, 600));
		send_req(request(CMD_COUNT, 0, 0, 1'b1, 0));
		send_req(request(CMD_FIND, 0, 0, 1'b1, 1));
		send_req(request(CMD_READ_BIT, 517, MAP_BITS - 1, 1'b1, SPAN_MAX));
		// unknown commands change nothing
		send_req(request(CMD_FIRST_UNUSED, 3, 900, 1'b0, 1000));
		send_req(request(CMD_FIRST_UNUSED + 1'b1, 0, MAP_BITS - 1, 1'b0, SPAN_MAX));
		send_req(request(CMD_LAST_CODE, MAP_BITS - 1, 0, 1'b1, MAP_BITS));

		for (int n = 0; n < N_RANDOM; n++) begin
			// halfway, the response side holds off while requests keep coming
			if (n == N_RANDOM / 2) begin
				hold_request  = 1'b1;
				tx_nogap_left = 20;
			end
			send_req(random_request());
		end
		req_valid = 1'b0;

		while (sb.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
